// ===== rtl/core/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared codes, state type and controller/datapath interface structs for the
// buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int WORD_W  = 32;
    localparam int ORDER_W = 4;
    localparam int CMD_W   = 2;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_LOAD_INIT,
        DP_SWEEP,
        DP_SCAN_RD,
        DP_SCAN_NEXT,
        DP_TAKE,
        DP_SPLIT_RD,
        DP_SPLIT_WR,
        DP_FREE_RD,
        DP_MERGE,
        DP_SET_RD,
        DP_SET_WR
    } dp_op_t;

    typedef enum logic [1:0] {
        RES_FAIL,
        RES_ZERO,
        RES_ALLOC,
        RES_FREE
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLR_RST,
        ST_CLR_INIT,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SPLIT_RD,
        ST_SPLIT_WR,
        ST_FIN_ALLOC,
        ST_FREE_RD,
        ST_FREE_CHK,
        ST_SET_WR,
        ST_FIN_FAIL
    } state_t;

    typedef struct packed {
        dp_op_t op;
        logic   emit;
        res_t   res;
    } ctl_cmd_t;

    typedef struct packed {
        logic word_hit;
        logic last_word;
        logic k_max;
        logic k_gt_want;
        logic k_gt_want1;
        logic mate_set;
    } dp_stat_t;

endpackage

// ===== rtl/core/bpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer for allocate, free and init requests; drives datapath commands.
// ----------------------------------------------------------------------------
module bpa_ctrl #(
    parameter int MAX_ORDER = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bpa_pkg::CMD_W-1:0]   cmd,
    input  logic [bpa_pkg::ORDER_W-1:0] order,
    input  bpa_pkg::dp_stat_t           stat,
    output bpa_pkg::ctl_cmd_t           ctl,
    output logic                        busy
);
    import bpa_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR_RST;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl.op     = DP_NOP;
        ctl.emit   = 1'b0;
        ctl.res    = RES_FAIL;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (cmd == CMD_INIT)
                    begin
                        ctl.op     = DP_LOAD_INIT;
                        state_next = ST_CLR_INIT;
                    end
                    else if (cmd == CMD_NOP || order > ORDER_W'(MAX_ORDER))
                    begin
                        state_next = ST_FIN_FAIL;
                    end
                    else
                    begin
                        ctl.op     = DP_LOAD;
                        state_next = (cmd == CMD_ALLOC) ? ST_SCAN_RD : ST_FREE_RD;
                    end
                end
            end
            ST_CLR_RST:
            begin
                ctl.op = DP_SWEEP;
                if (stat.k_max && stat.last_word)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLR_INIT:
            begin
                ctl.op = DP_SWEEP;
                if (stat.k_max && stat.last_word)
                begin
                    ctl.emit   = 1'b1;
                    ctl.res    = RES_ZERO;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN_RD:
            begin
                ctl.op     = DP_SCAN_RD;
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                if (stat.word_hit)
                begin
                    ctl.op     = DP_TAKE;
                    state_next = stat.k_gt_want ? ST_SPLIT_RD : ST_FIN_ALLOC;
                end
                else if (stat.last_word && stat.k_max)
                begin
                    ctl.emit   = 1'b1;
                    ctl.res    = RES_FAIL;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctl.op     = DP_SCAN_NEXT;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SPLIT_RD:
            begin
                ctl.op     = DP_SPLIT_RD;
                state_next = ST_SPLIT_WR;
            end
            ST_SPLIT_WR:
            begin
                ctl.op     = DP_SPLIT_WR;
                state_next = stat.k_gt_want1 ? ST_SPLIT_RD : ST_FIN_ALLOC;
            end
            ST_FIN_ALLOC:
            begin
                ctl.emit   = 1'b1;
                ctl.res    = RES_ALLOC;
                state_next = ST_IDLE;
            end
            ST_FREE_RD:
            begin
                // at the top order there is no buddy: go straight to setting the bit
                if (stat.k_max)
                begin
                    ctl.op     = DP_SET_RD;
                    state_next = ST_SET_WR;
                end
                else
                begin
                    ctl.op     = DP_FREE_RD;
                    state_next = ST_FREE_CHK;
                end
            end
            ST_FREE_CHK:
            begin
                if (stat.mate_set)
                begin
                    ctl.op     = DP_MERGE;
                    state_next = ST_FREE_RD;
                end
                else
                begin
                    ctl.op     = DP_SET_RD;
                    state_next = ST_SET_WR;
                end
            end
            ST_SET_WR:
            begin
                ctl.op     = DP_SET_WR;
                ctl.emit   = 1'b1;
                ctl.res    = RES_FREE;
                state_next = ST_IDLE;
            end
            ST_FIN_FAIL:
            begin
                ctl.emit   = 1'b1;
                ctl.res    = RES_FAIL;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== rtl/core/bpa_dpath.sv =====
// ----------------------------------------------------------------------------
// bpa_dpath
// Free-bit memory (32-bit words, orders stacked), block/order registers,
// carve word generator and result registers.
// ----------------------------------------------------------------------------
module bpa_dpath #(
    parameter int NUM_PAGES = 4096,
    parameter int MAX_ORDER = 10,
    parameter int PAGE_W    = $clog2(NUM_PAGES)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bpa_pkg::ctl_cmd_t           ctl,
    input  logic [bpa_pkg::ORDER_W-1:0] order,
    input  logic [PAGE_W-1:0]           page_index,
    input  logic                        region_we,
    input  logic [PAGE_W:0]             region_pages,
    output bpa_pkg::dp_stat_t           stat,
    output logic                        done,
    output logic                        status,
    output logic [PAGE_W-1:0]           page_index_res,
    output logic [bpa_pkg::ORDER_W-1:0] block_order
);
    import bpa_pkg::*;

    localparam int JW = PAGE_W - 5;

    function automatic int words_of(input int k);
        int n;
        n = NUM_PAGES >> k;
        return (n >= WORD_W) ? (n >> 5) : 1;
    endfunction

    function automatic int base_of(input int k);
        int s;
        s = 0;
        for (int i = 0; i < k; i++)
        begin
            s += words_of(i);
        end
        return s;
    endfunction

    localparam int DEPTH = base_of(MAX_ORDER + 1);
    localparam int AW    = $clog2(DEPTH);

    logic [AW-1:0] base_tab     [MAX_ORDER+1];
    logic [JW-1:0] words_m1_tab [MAX_ORDER+1];

    for (genvar g = 0; g <= MAX_ORDER; g++)
    begin : g_tab
        assign base_tab[g]     = AW'(base_of(g));
        assign words_m1_tab[g] = JW'(words_of(g) - 1);
    end

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    logic [PAGE_W:0]      region_reg;
    logic                 zero_reg;
    logic [ORDER_W-1:0]   k_reg, k_next;
    logic [ORDER_W-1:0]   want_reg;
    logic [JW-1:0]        j_reg, j_next;
    logic [PAGE_W-1:0]    b_reg;
    logic                 done_reg;
    logic                 status_reg;
    logic [PAGE_W-1:0]    page_res_reg;
    logic [ORDER_W-1:0]   order_res_reg;

    logic [ORDER_W-1:0]   a_k;
    logic [PAGE_W-1:0]    a_blk;
    logic [AW-1:0]        addr;
    logic                 we;
    logic                 re;
    logic [WORD_W-1:0]    wdata;
    logic [WORD_W-1:0]    carve_word;
    logic [PAGE_W:0]      lim;
    logic [4:0]           pe;
    logic                 last_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_reg <= (PAGE_W+1)'(NUM_PAGES);
        end
        else if (region_we)
        begin
            region_reg <= region_pages;
        end
    end

    assign lim       = (region_reg > (PAGE_W+1)'(NUM_PAGES)) ?
                       (PAGE_W+1)'(NUM_PAGES) : region_reg;
    assign last_word = (j_reg == words_m1_tab[k_reg]);

    // init content of word j at order k, built directly from the region size (all zeros in the reset clearing pass)
    always_comb
    begin
        logic [PAGE_W-1:0] blk;
        logic [PAGE_W-1:0] tgt;
        tgt = PAGE_W'((lim >> (k_reg + ORDER_W'(1))) << 1);
        for (int i = 0; i < WORD_W; i++)
        begin
            blk = {j_reg, 5'(i)};
            if (zero_reg)
            begin
                carve_word[i] = 1'b0;
            end
            else if (k_reg == ORDER_W'(MAX_ORDER))
            begin
                carve_word[i] = ({1'b0, blk} < (lim >> MAX_ORDER));
            end
            else
            begin
                carve_word[i] = lim[k_reg] && (blk == tgt);
            end
        end
    end

    always_comb
    begin
        pe = 5'd0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (rdata_reg[i])
            begin
                pe = 5'(i);
            end
        end
    end

    always_comb
    begin
        a_k   = k_reg;
        a_blk = b_reg;
        we    = 1'b0;
        re    = 1'b0;
        wdata = rdata_reg;
        addr  = base_tab[k_reg] + AW'(j_reg);
        case (ctl.op)
            DP_SWEEP:
            begin
                we    = 1'b1;
                wdata = carve_word;
            end
            DP_SCAN_RD:
            begin
                re = 1'b1;
            end
            DP_TAKE:
            begin
                we    = 1'b1;
                wdata = rdata_reg & ~(WORD_W'(1) << pe);
            end
            DP_SPLIT_RD, DP_SPLIT_WR:
            begin
                a_k   = k_reg - ORDER_W'(1);
                a_blk = b_reg << 1;
                addr  = base_tab[a_k] + AW'(a_blk >> 5);
                re    = (ctl.op == DP_SPLIT_RD);
                we    = (ctl.op == DP_SPLIT_WR);
                wdata = rdata_reg | (WORD_W'(1) << {b_reg[3:0], 1'b0});
            end
            DP_FREE_RD, DP_MERGE:
            begin
                a_blk = b_reg ^ PAGE_W'(1);
                addr  = base_tab[a_k] + AW'(a_blk >> 5);
                re    = (ctl.op == DP_FREE_RD);
                we    = (ctl.op == DP_MERGE);
                wdata = rdata_reg & ~(WORD_W'(1) << (b_reg[4:0] ^ 5'd1));
            end
            DP_SET_RD, DP_SET_WR:
            begin
                addr  = base_tab[a_k] + AW'(a_blk >> 5);
                re    = (ctl.op == DP_SET_RD);
                we    = (ctl.op == DP_SET_WR);
                wdata = rdata_reg | (WORD_W'(1) << b_reg[4:0]);
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    // advance to the next word, rolling over into the next order; hold at the top
    always_comb
    begin
        if (last_word)
        begin
            k_next = (k_reg == ORDER_W'(MAX_ORDER)) ? k_reg : k_reg + ORDER_W'(1);
            j_next = '0;
        end
        else
        begin
            k_next = k_reg;
            j_next = j_reg + JW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg    <= '0;
            j_reg    <= '0;
            zero_reg <= 1'b1;
        end
        else
        begin
            case (ctl.op)
                DP_LOAD:
                begin
                    k_reg    <= order;
                    j_reg    <= '0;
                    zero_reg <= 1'b0;
                end
                DP_LOAD_INIT:
                begin
                    k_reg    <= '0;
                    j_reg    <= '0;
                    zero_reg <= 1'b0;
                end
                DP_SWEEP, DP_SCAN_NEXT:
                begin
                    k_reg <= k_next;
                    j_reg <= j_next;
                end
                DP_SPLIT_WR:
                begin
                    k_reg <= k_reg - ORDER_W'(1);
                end
                DP_MERGE:
                begin
                    k_reg <= k_reg + ORDER_W'(1);
                end
                default:
                begin
                    k_reg <= k_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctl.op)
            DP_LOAD:
            begin
                want_reg <= order;
                b_reg    <= page_index >> order;
            end
            DP_TAKE:
            begin
                b_reg <= {j_reg, pe};
            end
            DP_SPLIT_WR:
            begin
                b_reg <= {b_reg[PAGE_W-2:0], 1'b1};
            end
            DP_MERGE:
            begin
                b_reg <= b_reg >> 1;
            end
            default:
            begin
                b_reg <= b_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            case (ctl.res)
                RES_ALLOC:
                begin
                    status_reg    <= 1'b0;
                    page_res_reg  <= PAGE_W'(b_reg << want_reg);
                    order_res_reg <= want_reg;
                end
                RES_FREE:
                begin
                    status_reg    <= 1'b0;
                    page_res_reg  <= PAGE_W'(b_reg << k_reg);
                    order_res_reg <= k_reg;
                end
                RES_ZERO:
                begin
                    status_reg    <= 1'b0;
                    page_res_reg  <= '0;
                    order_res_reg <= '0;
                end
                default:
                begin
                    status_reg    <= 1'b1;
                    page_res_reg  <= '0;
                    order_res_reg <= '0;
                end
            endcase
        end
    end

    assign stat.word_hit   = |rdata_reg;
    assign stat.last_word  = last_word;
    assign stat.k_max      = (k_reg == ORDER_W'(MAX_ORDER));
    assign stat.k_gt_want  = (k_reg > want_reg);
    assign stat.k_gt_want1 = ({1'b0, k_reg} > ({1'b0, want_reg} + (ORDER_W+1)'(1)));
    assign stat.mate_set   = rdata_reg[b_reg[4:0] ^ 5'd1];

    assign done           = done_reg;
    assign status         = status_reg;
    assign page_index_res = page_res_reg;
    assign block_order    = order_res_reg;

endmodule

// ===== rtl/core/buddy_page_allocator.sv =====
// Sequence after accept: allocate reads and checks each 32-bit free-bit word scanned, then
//   reads and writes each split level and finishes; free reads and checks each merge level, then
//   reads and writes the free bit; init writes every memory word (258 words at defaults); fail finishes.
// Throughput: one request at a time; busy stays high until the request is finished.
// The result shows in the cycle after completion with done, which is high for one cycle; no stall.
// Reset: asynchronous; a clearing pass over every memory word follows with busy high; region resets.
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy allocator of page blocks, orders 0 to MAX_ORDER, one free bit per block.
// ----------------------------------------------------------------------------
module buddy_page_allocator #(
    parameter int NUM_PAGES = 4096,
    parameter int MAX_ORDER = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [bpa_pkg::CMD_W-1:0]      cmd,
    input  logic [bpa_pkg::ORDER_W-1:0]    order,
    input  logic [$clog2(NUM_PAGES)-1:0]   page_index,
    input  logic                           region_we,
    input  logic [$clog2(NUM_PAGES):0]     region_pages,
    output logic                           done,
    output logic                           status,
    output logic [$clog2(NUM_PAGES)-1:0]   page_index_res,
    output logic [bpa_pkg::ORDER_W-1:0]    block_order
);
    import bpa_pkg::*;

    ctl_cmd_t ctl;
    dp_stat_t stat;

    bpa_ctrl #(
        .MAX_ORDER (MAX_ORDER)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .order (order),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    bpa_dpath #(
        .NUM_PAGES (NUM_PAGES),
        .MAX_ORDER (MAX_ORDER)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .order          (order),
        .page_index     (page_index),
        .region_we      (region_we),
        .region_pages   (region_pages),
        .stat           (stat),
        .done           (done),
        .status         (status),
        .page_index_res (page_index_res),
        .block_order    (block_order)
    );

endmodule
